// ===== sv/fsp_pkg.sv =====
package fsp_pkg;

   localparam int CAPACITY        = 512;
   localparam int MAX_FRAME_BYTES = 256;
   localparam int PREFIX_BYTES    = 2;
   localparam int BATCH_LIMIT     = 255;
   localparam int SLOT_W          = $clog2(CAPACITY);
   localparam int CNT_W           = $clog2(CAPACITY + 1);
   localparam int CSR_IDX_W       = 1;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_PEEK   = 3'd1;
   localparam logic [2:0] OP_POP    = 3'd2;
   localparam logic [2:0] OP_TAKE   = 3'd3;
   localparam logic [2:0] OP_RECORD = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SIZE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOW_REASON = 1'd1;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] sequence_req;
      logic [63:0] sample_pos;
      logic [8:0]  frame_bytes;
      logic [15:0] frame_flags;
      logic [15:0] packet_limit;
      logic [15:0] buffer_size;
      logic [31:0] missing_count;
      logic [7:0]  gap_reason_in;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [8:0]  slot;
      logic [31:0] first_sequence;
      logic [63:0] first_sample_pos;
      logic [7:0]  batch_frames;
      logic [15:0] batch_bytes;
      logic [31:0] gap_count;
      logic [7:0]  gap_reason;
      logic [9:0]  depth;
      logic        gap_pending;
      logic [31:0] dropped_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [63:0] sample;
      logic [8:0]  len;
      logic [15:0] flags;
   } entry_type;

   typedef struct packed {
      logic load;
      logic drop;
      logic push_wr;
      logic peek_step;
      logic pop_step;
      logic exec_misc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       len_bad;
      logic       full;
      logic       empty;
      logic       fit;
      logic       last_peek;
      logic       pop_over;
      logic       pop_last;
   } sts_type;

endpackage

// ===== sv/fsp_if.sv =====
interface fsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] sequence_req;
   logic [63:0] sample_pos;
   logic [8:0]  frame_bytes;
   logic [15:0] frame_flags;
   logic [15:0] packet_limit;
   logic [15:0] buffer_size;
   logic [31:0] missing_count;
   logic [7:0]  gap_reason_in;
   modport source (output valid, op, sequence_req, sample_pos, frame_bytes, frame_flags,
                   packet_limit, buffer_size, missing_count, gap_reason_in, input ready);
   modport sink (input valid, op, sequence_req, sample_pos, frame_bytes, frame_flags,
                 packet_limit, buffer_size, missing_count, gap_reason_in, output ready);
endinterface

interface fsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [8:0]  slot;
   logic [31:0] first_sequence;
   logic [63:0] first_sample_pos;
   logic [7:0]  batch_frames;
   logic [15:0] batch_bytes;
   logic [31:0] gap_count;
   logic [7:0]  gap_reason;
   logic [9:0]  depth;
   logic        gap_pending;
   logic [31:0] dropped_count;
   modport source (output valid, ok, slot, first_sequence, first_sample_pos, batch_frames,
                   batch_bytes, gap_count, gap_reason, depth, gap_pending, dropped_count,
                   input ready);
   modport sink (input valid, ok, slot, first_sequence, first_sample_pos, batch_frames,
                 batch_bytes, gap_count, gap_reason, depth, gap_pending, dropped_count,
                 output ready);
endinterface

interface fsp_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] reg_index;
   logic [7:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/frame_spool_with_gap_tracking.sv =====
// Frame spool: a ring of up to 512 frame descriptors with a pending gap record.
// The req_ch channel takes one operation word (push, peek batch, pop through,
// take gap, record gap, clear); the rsp_ch channel returns exactly one result
// word for each. The csr_ch channel writes the header size (index 0) and the
// overflow reason (index 1); it is ready whenever reset is low and should be
// used only while no operation is outstanding.
// An operation is held in the block from acceptance until its result is
// registered: after dispatch, push goes through the write step, preceded by a
// read step when the ring is full and the oldest frame is dropped; peek and
// pop step through the frames they examine, pop including a frame that stops
// the walk without leaving; a refused push and the other operations go from
// dispatch straight to the result. The walks read one descriptor per cycle
// from the single ring memory. A new word can be accepted at the edge after
// the previous result is registered, even if the receiver has not yet
// taken it; if the receiver stalls, the next result waits in the block and
// req_ch stays not ready until the output register frees.
// Synchronous reset empties the ring, clears the drop count, the gap record
// and both registers; descriptor contents are not cleared.
// Neither req_ch nor csr_ch is ready while reset is high.
module frame_spool_with_gap_tracking (
   input  logic         clock,
   input  logic         reset,
   fsp_req_if.sink      req_ch,
   fsp_rsp_if.source    rsp_ch,
   fsp_csr_if.sink      csr_ch
);

   fsp_pkg::req_type req_word;
   fsp_pkg::rsp_type rsp_word;
   fsp_pkg::cmd_type cmd;
   fsp_pkg::sts_type sts;

   assign req_word.op            = req_ch.op;
   assign req_word.sequence_req  = req_ch.sequence_req;
   assign req_word.sample_pos    = req_ch.sample_pos;
   assign req_word.frame_bytes   = req_ch.frame_bytes;
   assign req_word.frame_flags   = req_ch.frame_flags;
   assign req_word.packet_limit  = req_ch.packet_limit;
   assign req_word.buffer_size   = req_ch.buffer_size;
   assign req_word.missing_count = req_ch.missing_count;
   assign req_word.gap_reason_in = req_ch.gap_reason_in;

   assign rsp_ch.ok               = rsp_word.ok;
   assign rsp_ch.slot             = rsp_word.slot;
   assign rsp_ch.first_sequence   = rsp_word.first_sequence;
   assign rsp_ch.first_sample_pos = rsp_word.first_sample_pos;
   assign rsp_ch.batch_frames     = rsp_word.batch_frames;
   assign rsp_ch.batch_bytes      = rsp_word.batch_bytes;
   assign rsp_ch.gap_count        = rsp_word.gap_count;
   assign rsp_ch.gap_reason       = rsp_word.gap_reason;
   assign rsp_ch.depth            = rsp_word.depth;
   assign rsp_ch.gap_pending      = rsp_word.gap_pending;
   assign rsp_ch.dropped_count    = rsp_word.dropped_count;

   assign csr_ch.ready = !reset;

   fsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_i     (req_word),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.reg_index),
      .csr_data  (csr_ch.wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_o     (rsp_word)
   );

endmodule

// ===== sv/fsp_ctrl.sv =====
module fsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fsp_pkg::sts_type  sts,
   output fsp_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DISP    = 3'd1;
   localparam logic [2:0] S_PUSH_RD = 3'd2;
   localparam logic [2:0] S_PUSH_WR = 3'd3;
   localparam logic [2:0] S_WALK    = 3'd4;
   localparam logic [2:0] S_POP     = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.op)
               fsp_pkg::OP_PUSH: begin
                  if (sts.len_bad) state_in = S_DONE;
                  else if (sts.full) state_in = S_PUSH_RD;
                  else state_in = S_PUSH_WR;
               end
               fsp_pkg::OP_PEEK: begin
                  state_in = sts.empty ? S_DONE : S_WALK;
               end
               fsp_pkg::OP_POP: begin
                  cmd.exec_misc = 1'b1;
                  state_in = sts.empty ? S_DONE : S_POP;
               end
               default: begin
                  cmd.exec_misc = 1'b1;
                  state_in = S_DONE;
               end
            endcase
         end
         S_PUSH_RD: begin
            cmd.drop = 1'b1;
            state_in = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            cmd.push_wr = 1'b1;
            state_in = S_DONE;
         end
         S_WALK: begin
            if (sts.fit) begin
               cmd.peek_step = 1'b1;
               if (sts.last_peek) state_in = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_POP: begin
            if (sts.pop_over) begin
               state_in = S_DONE;
            end else begin
               cmd.pop_step = 1'b1;
               if (sts.pop_last) state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/fsp_datapath.sv =====
module fsp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  fsp_pkg::req_type                  req_i,
   input  logic                              csr_valid,
   input  logic [fsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_data,
   input  fsp_pkg::cmd_type                  cmd,
   output fsp_pkg::sts_type                  sts,
   output fsp_pkg::rsp_type                  rsp_o
);

   fsp_pkg::entry_type mem [fsp_pkg::CAPACITY];
   fsp_pkg::entry_type rd_ff;

   fsp_pkg::req_type req_ff, req_in;
   fsp_pkg::rsp_type out_ff, out_in;

   logic [fsp_pkg::SLOT_W-1:0] head_ff, head_in;
   logic [fsp_pkg::CNT_W-1:0]  held_ff, held_in;
   logic [31:0]                drop_ff, drop_in;
   logic                       gvalid_ff, gvalid_in;
   logic [31:0]                gseq_ff, gseq_in;
   logic [63:0]                gsamp_ff, gsamp_in;
   logic [31:0]                gmiss_ff, gmiss_in;
   logic [7:0]                 gcode_ff, gcode_in;
   logic [7:0]                 hdr_ff, hdr_in;
   logic [7:0]                 ovf_ff, ovf_in;
   logic [fsp_pkg::SLOT_W-1:0] walk_ff, walk_in;
   logic [15:0]                plen_ff, plen_in;
   logic                       ok_ff, ok_in;
   logic [fsp_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]                fseq_ff, fseq_in;
   logic [63:0]                fsamp_ff, fsamp_in;
   logic [31:0]                gcnt_ff, gcnt_in;
   logic [7:0]                 grsn_ff, grsn_in;

   logic [fsp_pkg::SLOT_W-1:0] tail;
   logic [fsp_pkg::SLOT_W-1:0] rd_addr;
   logic [9:0]                 fbytes;
   logic [17:0]                sum_pkt;
   logic [17:0]                sum_buf;
   logic [fsp_pkg::CNT_W-1:0]  walk_next;

   assign tail      = head_ff + held_ff[fsp_pkg::SLOT_W-1:0];
   assign rd_addr   = head_in + walk_in;
   assign fbytes    = 10'(fsp_pkg::PREFIX_BYTES) + {1'b0, rd_ff.len};
   assign sum_pkt   = 18'(hdr_ff) + 18'(plen_ff) + 18'(fbytes);
   assign sum_buf   = 18'(plen_ff) + 18'(fbytes);
   assign walk_next = fsp_pkg::CNT_W'(walk_ff) + fsp_pkg::CNT_W'(1);

   always_comb begin
      sts           = '0;
      sts.op        = req_ff.op;
      sts.len_bad   = (req_ff.frame_bytes > 9'(fsp_pkg::MAX_FRAME_BYTES));
      sts.full      = (held_ff == fsp_pkg::CNT_W'(fsp_pkg::CAPACITY));
      sts.empty     = (held_ff == '0);
      sts.fit       = !(sum_pkt > 18'(req_ff.packet_limit)) &&
                      !(sum_buf > 18'(req_ff.buffer_size));
      sts.last_peek = (walk_next == held_ff) ||
                      (walk_next == fsp_pkg::CNT_W'(fsp_pkg::BATCH_LIMIT));
      sts.pop_over  = (rd_ff.seq > req_ff.sequence_req);
      sts.pop_last  = (rd_ff.seq == req_ff.sequence_req) ||
                      (held_ff == fsp_pkg::CNT_W'(1));
   end

   always_comb begin
      req_in    = req_ff;
      out_in    = out_ff;
      head_in   = head_ff;
      held_in   = held_ff;
      drop_in   = drop_ff;
      gvalid_in = gvalid_ff;
      gseq_in   = gseq_ff;
      gsamp_in  = gsamp_ff;
      gmiss_in  = gmiss_ff;
      gcode_in  = gcode_ff;
      hdr_in    = hdr_ff;
      ovf_in    = ovf_ff;
      walk_in   = walk_ff;
      plen_in   = plen_ff;
      ok_in     = ok_ff;
      slot_in   = slot_ff;
      fseq_in   = fseq_ff;
      fsamp_in  = fsamp_ff;
      gcnt_in   = gcnt_ff;
      grsn_in   = grsn_ff;

      if (cmd.load) begin
         req_in   = req_i;
         walk_in  = '0;
         plen_in  = '0;
         ok_in    = 1'b0;
         slot_in  = '0;
         fseq_in  = '0;
         fsamp_in = '0;
         gcnt_in  = '0;
         grsn_in  = '0;
      end

      if (cmd.drop) begin
         if (!gvalid_ff) begin
            gvalid_in = 1'b1;
            gseq_in   = rd_ff.seq;
            gsamp_in  = rd_ff.sample;
            gmiss_in  = 32'd1;
            gcode_in  = ovf_ff;
         end else begin
            gmiss_in  = gmiss_ff + 32'd1;
         end
         head_in = head_ff + fsp_pkg::SLOT_W'(1);
         held_in = held_ff - fsp_pkg::CNT_W'(1);
         drop_in = drop_ff + 32'd1;
      end

      if (cmd.push_wr) begin
         held_in = held_ff + fsp_pkg::CNT_W'(1);
         ok_in   = 1'b1;
         slot_in = tail;
      end

      if (cmd.peek_step) begin
         if (walk_ff == '0) begin
            ok_in    = 1'b1;
            slot_in  = head_ff;
            fseq_in  = rd_ff.seq;
            fsamp_in = rd_ff.sample;
         end
         plen_in = plen_ff + 16'(fbytes);
         walk_in = walk_ff + fsp_pkg::SLOT_W'(1);
      end

      if (cmd.pop_step) begin
         head_in = head_ff + fsp_pkg::SLOT_W'(1);
         held_in = held_ff - fsp_pkg::CNT_W'(1);
      end

      if (cmd.exec_misc) begin
         case (req_ff.op)
            fsp_pkg::OP_POP: begin
               ok_in = 1'b1;
            end
            fsp_pkg::OP_TAKE: begin
               if (gvalid_ff) begin
                  ok_in     = 1'b1;
                  fseq_in   = gseq_ff;
                  fsamp_in  = gsamp_ff;
                  gcnt_in   = gmiss_ff;
                  grsn_in   = gcode_ff;
                  gvalid_in = 1'b0;
                  gseq_in   = '0;
                  gsamp_in  = '0;
                  gmiss_in  = '0;
                  gcode_in  = '0;
               end
            end
            fsp_pkg::OP_RECORD: begin
               ok_in = 1'b1;
               if (!gvalid_ff) begin
                  gvalid_in = 1'b1;
                  gseq_in   = req_ff.sequence_req;
                  gsamp_in  = req_ff.sample_pos;
                  gmiss_in  = req_ff.missing_count;
                  gcode_in  = req_ff.gap_reason_in;
               end else begin
                  gmiss_in  = gmiss_ff + req_ff.missing_count;
               end
            end
            fsp_pkg::OP_CLEAR: begin
               ok_in     = 1'b1;
               head_in   = '0;
               held_in   = '0;
               drop_in   = '0;
               gvalid_in = 1'b0;
               gseq_in   = '0;
               gsamp_in  = '0;
               gmiss_in  = '0;
               gcode_in  = '0;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end

      if (csr_valid) begin
         case (csr_index)
            fsp_pkg::CSR_HEADER_SIZE:     hdr_in = csr_data;
            fsp_pkg::CSR_OVERFLOW_REASON: ovf_in = csr_data;
            default:                      hdr_in = hdr_ff;
         endcase
      end

      if (cmd.emit) begin
         out_in.ok               = ok_ff;
         out_in.slot             = 9'(slot_ff);
         out_in.first_sequence   = fseq_ff;
         out_in.first_sample_pos = fsamp_ff;
         out_in.batch_frames     = walk_ff[7:0];
         out_in.batch_bytes      = plen_ff;
         out_in.gap_count        = gcnt_ff;
         out_in.gap_reason       = grsn_ff;
         out_in.depth            = 10'(held_ff);
         out_in.gap_pending      = gvalid_ff;
         out_in.dropped_count    = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (cmd.push_wr) begin
         mem[tail] <= '{seq:    req_ff.sequence_req,
                        sample: req_ff.sample_pos,
                        len:    req_ff.frame_bytes,
                        flags:  req_ff.frame_flags};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         held_ff   <= '0;
         drop_ff   <= '0;
         gvalid_ff <= 1'b0;
         gseq_ff   <= '0;
         gsamp_ff  <= '0;
         gmiss_ff  <= '0;
         gcode_ff  <= '0;
         hdr_ff    <= '0;
         ovf_ff    <= '0;
         walk_ff   <= '0;
      end else begin
         head_ff   <= head_in;
         held_ff   <= held_in;
         drop_ff   <= drop_in;
         gvalid_ff <= gvalid_in;
         gseq_ff   <= gseq_in;
         gsamp_ff  <= gsamp_in;
         gmiss_ff  <= gmiss_in;
         gcode_ff  <= gcode_in;
         hdr_ff    <= hdr_in;
         ovf_ff    <= ovf_in;
         walk_ff   <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      out_ff   <= out_in;
      plen_ff  <= plen_in;
      ok_ff    <= ok_in;
      slot_ff  <= slot_in;
      fseq_ff  <= fseq_in;
      fsamp_ff <= fsamp_in;
      gcnt_ff  <= gcnt_in;
      grsn_ff  <= grsn_in;
   end

   assign rsp_o = out_ff;

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= fsp_pkg::CNT_W'(fsp_pkg::CAPACITY))
      else $error("held count above capacity");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> held_ff == fsp_pkg::CNT_W'(fsp_pkg::CAPACITY))
      else $error("drop without a full ring");

   a_batch_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.peek_step |-> fsp_pkg::CNT_W'(walk_ff) < fsp_pkg::CNT_W'(fsp_pkg::BATCH_LIMIT))
      else $error("batch walked past its limit");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_step |-> held_ff != '0)
      else $error("pop from an empty ring");
`endif

endmodule
